// ----- hw/rtl/ipv4_address_blocklist_table_assert.svh -----
// assertion macros used by the blocklist table top level
`ifndef IPV4_ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH
`define IPV4_ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- hw/rtl/ipv4bl_pkg.sv -----
// types and constants shared by the blocklist table modules
package ipv4bl_pkg;

	localparam int ADDR_W     = 32;
	localparam int OPCODE_W   = 2;
	localparam int ENT_CNT_W  = 5;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_APPLY = 1'b1
	} state_t;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic cmp;  // compare stored entry against the incoming address
		logic ins;  // shift the chain up, key enters at cell 0
		logic del;  // cells at or above the hit take their upper neighbor
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ipv4bl_cell.sv -----
// one table slot: stored address, local compare and neighbor shifting
module ipv4bl_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                        clk,
	input  ipv4bl_pkg::cell_ctl_t       ctl,
	input  logic [CW-1:0]               count,
	input  logic [ipv4bl_pkg::ADDR_W-1:0] key,
	input  logic [ipv4bl_pkg::ADDR_W-1:0] prev_addr,
	input  logic [ipv4bl_pkg::ADDR_W-1:0] next_addr,
	input  logic                        seen_in,
	output logic [ipv4bl_pkg::ADDR_W-1:0] addr,
	output logic                        hit,
	output logic                        seen_out
);
	import ipv4bl_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [ADDR_W-1:0] addr_q;
	logic              hit_q;

	// slot is live only below the fill level
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q <= (addr_q == key) && (count > IDX_C);
		end
	end

	// insert shifts up, delete closes the gap from above
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			addr_q <= prev_addr;
		end else if (ctl.del && seen_out) begin
			addr_q <= next_addr;
		end
	end

	assign seen_out = seen_in | hit_q;
	assign addr     = addr_q;
	assign hit      = hit_q;

endmodule

// ----- hw/rtl/ipv4bl_ctrl.sv -----
// request sequencing, fill count and result register
module ipv4bl_ctrl #(
	parameter int MAX_ENTRIES = 16,
	parameter int CW          = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ipv4bl_pkg::OPCODE_W-1:0] s_tuser,
	input  logic [ipv4bl_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ipv4bl_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                            any_hit,
	output ipv4bl_pkg::cell_ctl_t           ctl,
	output logic [ipv4bl_pkg::ADDR_W-1:0]   key,
	output logic [CW-1:0]                   count
);
	import ipv4bl_pkg::*;

	localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

	state_t            state_q, state_d;
	op_t               op_q;
	logic [ADDR_W-1:0] key_q;
	logic [CW-1:0]     count_q, count_d;
	logic              m_valid_q;
	logic              drop_q, drop_d;
	logic              status_q, status_d;
	logic              accept;
	logic              go;
	logic              full;

	assign accept = s_tvalid && s_tready;
	assign go     = (state_q == ST_APPLY) && (!m_valid_q || m_tready);
	assign full   = (count_q >= MAX_C);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// outputs: cell commands and the result of the request
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ctl      = '0;
		ctl.cmp  = accept;
		drop_d   = 1'b0;
		status_d = 1'b0;
		count_d  = count_q;
		if (go) begin
			unique case (op_q)
				OP_LOOKUP: begin
					drop_d = any_hit;
				end
				OP_ADD: begin
					if (full) begin
						status_d = 1'b1;
					end else if (!any_hit) begin
						ctl.ins = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				OP_DELETE: begin
					if (any_hit) begin
						ctl.del = 1'b1;
						count_d = count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tuser);
			key_q <= s_tdata[ADDR_W-1:0];
		end
		if (go) begin
			drop_q   <= drop_d;
			status_q <= status_d;
		end
	end

	// count only moves together with a new result, so it is read directly
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, ENT_CNT_W'(count_q), status_q, drop_q};
	assign key      = key_q;
	assign count    = count_q;

endmodule

// ----- hw/rtl/ipv4_address_blocklist_table.sv -----
// top level of the ipv4 address blocklist table
//
// Requests enter on the s_ stream: s_tuser carries the opcode (lookup, add,
// delete), s_tdata the address. Every request gives exactly one result on
// the m_ stream: drop, full status and the entry count after the request.
// The table is a chain of cells, one address each. On the accept edge every
// cell compares its entry with the address; the hits are then combined along
// the chain, and once the result register is free the table is updated: an
// add of a new address to a table with room shifts the chain up with the new
// address entering at cell 0, a delete pulls the cells at and above the hit
// down by one. m_tvalid rises at the update edge; a new request can be
// accepted only after that update, set by the compare cycle followed by the
// update cycle of the cell chain.
// s_tready is high while no request is being applied, also while a result
// waits for m_tready; if the receiver stalls, the next request waits in the
// update cycle until the result register frees up.
// Reset empties the table (count zero) at once; no clearing pass is needed.
`include "ipv4_address_blocklist_table_assert.svh"

module ipv4_address_blocklist_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	input  logic [31:0] s_tdata,   // [31:0] address
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] drop, [1] status, [6:2] entry_count, [7] zero
);
	import ipv4bl_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cell_ctl_t         ctl;
	logic [ADDR_W-1:0] key;
	logic [CW-1:0]     count;
	logic [ADDR_W-1:0] cell_addr [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hits;
	logic [MAX_ENTRIES:0]   seen;

	ipv4bl_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.CW         (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.any_hit (seen[MAX_ENTRIES]),
		.ctl     (ctl),
		.key     (key),
		.count   (count)
	);

	assign seen[0] = 1'b0;

	// the cell chain; cell 0 takes the key on insert, the top cell keeps itself
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [ADDR_W-1:0] prev_addr;
		logic [ADDR_W-1:0] next_addr;

		if (i == 0) begin : g_first
			assign prev_addr = key;
		end else begin : g_mid
			assign prev_addr = cell_addr[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign next_addr = cell_addr[i];
		end else begin : g_below
			assign next_addr = cell_addr[i+1];
		end

		ipv4bl_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count),
			.key      (s_tdata[ADDR_W-1:0]),
			.prev_addr(prev_addr),
			.next_addr(next_addr),
			.seen_in  (seen[i]),
			.addr     (cell_addr[i]),
			.hit      (hits[i]),
			.seen_out (seen[i+1])
		);
	end

	// checks on the table logic
	`ASSERT_IMPLIES(a_count_max, 1'b1, count <= CW'(MAX_ENTRIES), "entry count above table size")
	`ASSERT_IMPLIES(a_ins_del, ctl.ins || ctl.del, !(ctl.ins && ctl.del) && !s_tready,
		"insert and delete together or outside update cycle")
	`ASSERT_IMPLIES(a_hit_unique, !s_tready, $onehot0(hits), "address held in more than one cell")
	`ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"request accepted without an update cycle")

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the ipv4 address blocklist table
`timescale 1ns / 1ps

module tb_top;
	import ipv4bl_pkg::*;

	localparam int MAX_HELD = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 60;
	localparam int POOL_SIZE = 20;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ADDR_W-1:0]   address;
	} request_t;

	typedef struct packed {
		logic                 drop;
		logic                 status;
		logic [ENT_CNT_W-1:0] entry_count;
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] accept_cycle;
	} pending_verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [1:0]           s_tuser;
	logic [31:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	// shadow copy of the table
	logic [ADDR_W-1:0] blocked_addr [MAX_HELD];
	int                blocked_count = 0;

	request_t         request_q [$];
	pending_verdict_t verdict_q [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_arm = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          queued_total = 0;
	int          accepted = 0;
	int          results = 0;
	int          errors = 0;
	int          drops_seen = 0;
	int          refusals_seen = 0;
	int          peak_count = 0;
	logic [31:0] cycle_count = '0;
	request_t    cur_req;
	request_t    taken_req;
	verdict_t    got;
	pending_verdict_t want;

	ipv4_address_blocklist_table #(
		.MAX_ENTRIES(MAX_HELD)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// table behavior applied to one request, updates the shadow copy
	function automatic verdict_t apply_request(input request_t req);
		verdict_t v;
		int       hit;
		v = '0;
		hit = -1;
		for (int i = 0; i < blocked_count; i++)
			if (blocked_addr[i] == req.address)
				hit = i;
		case (req.opcode)
			OP_LOOKUP: v.drop = (hit >= 0);
			OP_ADD: begin
				if (blocked_count >= MAX_HELD) begin
					v.status = 1'b1;
				end else if (hit < 0) begin
					blocked_addr[blocked_count] = req.address;
					blocked_count++;
				end
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					blocked_addr[hit] = blocked_addr[blocked_count - 1];
					blocked_count--;
				end
			end
			default: ;
		endcase
		v.entry_count = blocked_count[ENT_CNT_W-1:0];
		return v;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken_req.opcode = s_tuser;
				taken_req.address = s_tdata;
				want.verdict = apply_request(taken_req);
				want.accept_cycle = cycle_count;
				if (want.verdict.drop)
					drops_seen++;
				if (want.verdict.status)
					refusals_seen++;
				if (blocked_count > peak_count)
					peak_count = blocked_count;
				verdict_q.push_back(want);
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.opcode;
					s_tdata <= cur_req.address;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (hold_seen != hold_arm) begin
			hold_seen <= hold_arm;
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.drop = m_tdata[0];
				got.status = m_tdata[1];
				got.entry_count = m_tdata[6:2];
				results++;
				// only requests accepted at an earlier edge may answer
				if (verdict_q.size() == 0 || verdict_q[0].accept_cycle == cycle_count) begin
					$error("result with no request waiting: drop %0d status %0d count %0d",
						got.drop, got.status, got.entry_count);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (got.drop !== want.verdict.drop) begin
						$error("drop mismatch: expected %0d, got %0d",
							want.verdict.drop, got.drop);
						errors++;
					end
					if (got.status !== want.verdict.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.verdict.status, got.status);
						errors++;
					end
					if (got.entry_count !== want.verdict.entry_count) begin
						$error("entry_count mismatch: expected %0d, got %0d",
							want.verdict.entry_count, got.entry_count);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, verdict_q.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_request(input logic [1:0] op, input logic [31:0] addr);
		request_t r;
		r.opcode = op;
		r.address = addr;
		request_q.push_back(r);
		queued_total++;
	endtask

	// random requests, mostly on a small address pool so the table fills and empties
	task automatic queue_random(input int n, input int add_pct);
		int          r;
		logic [1:0]  op;
		logic [31:0] addr;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < add_pct)
				op = OP_ADD;
			else if (r < add_pct + 25)
				op = OP_DELETE;
			else if (r < add_pct + 30)
				op = OP_UNUSED;
			else
				op = OP_LOOKUP;
			if ($urandom_range(99) < 80)
				addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
			else
				addr = $urandom;
			queue_request(op, addr);
		end
	endtask

	task automatic wait_drained();
		while (accepted != queued_total || verdict_q.size() != 0)
			@(negedge clk);
	endtask

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, duplicates, every opcode
		queue_request(OP_LOOKUP, 32'h0000_0000);
		queue_request(OP_DELETE, 32'h0000_0005);
		queue_request(OP_ADD, 32'h0000_0000);
		queue_request(OP_ADD, 32'hFFFF_FFFF);
		queue_request(OP_ADD, 32'h0000_0000);
		queue_request(OP_LOOKUP, 32'h0000_0000);
		queue_request(OP_LOOKUP, 32'hFFFF_FFFF);
		queue_request(OP_UNUSED, 32'hFFFF_FFFF);
		queue_request(OP_DELETE, 32'h5A5A_A5A5);
		queue_request(OP_DELETE, 32'h0000_0000);
		queue_request(OP_LOOKUP, 32'h0000_0000);
		// fill to capacity, then add when full, new and held
		for (int i = 1; i < MAX_HELD; i++)
			queue_request(OP_ADD, 32'h0A00_0000 + i);
		queue_request(OP_ADD, 32'hC0A8_0001);
		queue_request(OP_ADD, 32'hFFFF_FFFF);
		queue_request(OP_DELETE, 32'hFFFF_FFFF);
		queue_request(OP_LOOKUP, 32'hFFFF_FFFF);
		wait_drained();

		// no idling
		queue_random(80, 50);
		wait_drained();

		// sender idle most cycles
		send_idle_pct = 62;
		queue_random(80, 35);
		wait_drained();

		// receiver stalls most cycles
		send_idle_pct = 0;
		recv_stall_pct = 62;
		queue_random(80, 50);
		wait_drained();

		// both sides idle now and then
		send_idle_pct = 14;
		recv_stall_pct = 14;
		queue_random(80, 30);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(80, 45);
		hold_arm++;
		wait_drained();

		repeat (8) @(negedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d expected results never arrived", verdict_q.size());
			errors++;
		end
		$display("run covered %0d requests and %0d results in %0d cycles",
			accepted, results, cycle_count);
		$display("lookups dropped %0d, adds refused as full %0d, largest table %0d",
			drops_seen, refusals_seen, peak_count);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
